// ----- design/slr_pkg.sv -----
`default_nettype none

package slr_pkg;

	localparam int SEGID_W    = 4;
	localparam int ADDR_W     = 12;
	localparam int LEN_W      = 13;
	localparam int SLOT_W     = 8;
	localparam int WORD_W     = 32;
	localparam int COUNT_W    = 9;
	localparam int EXEC_W     = 13;
	localparam int JUMP_W     = 16;
	localparam int MOD_W      = 18;
	localparam int IN_DATA_W  = 80;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 48;

	typedef logic [1:0] cmd_t;

	localparam cmd_t CMD_SEG    = 2'd0;
	localparam cmd_t CMD_ORDER  = 2'd1;
	localparam cmd_t CMD_BRANCH = 2'd2;
	localparam cmd_t CMD_CODE   = 2'd3;

	typedef struct packed {
		logic [ADDR_W-1:0]  offset;
		logic [SEGID_W-1:0] dest;
	} br_entry_t;

	typedef struct packed {
		logic               en;
		logic [SLOT_W-1:0]  slot;
		logic [ADDR_W-1:0]  offset;
		logic [SEGID_W-1:0] dest;
	} br_write_t;

	typedef struct packed {
		logic              en;
		logic              first;
		logic [ADDR_W-1:0] address;
	} br_lookup_t;

	typedef struct packed {
		logic               hit;
		logic [SEGID_W-1:0] dest;
	} br_match_t;

endpackage

`default_nettype wire

// ----- design/slr_branch_match.sv -----
`default_nettype none

module slr_branch_match
	import slr_pkg::*;
#(
	parameter int BRANCH_ENTRIES = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [COUNT_W-1:0] branch_count,
	input  wire br_write_t          wr,
	input  wire br_lookup_t         lk,
	output br_match_t               match
);

	localparam int IDX_W = (BRANCH_ENTRIES > 1) ? $clog2(BRANCH_ENTRIES) : 1;
	localparam int DEPTH = 2 ** IDX_W;

	br_entry_t          br_mem [DEPTH];
	br_entry_t          pre_q;
	br_entry_t          ent0_q;
	br_entry_t          cur;
	br_entry_t          wdata;
	logic [COUNT_W-1:0] ptr_q;
	logic [COUNT_W-1:0] p_eff;
	logic [COUNT_W-1:0] ptr_next;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   wr_addr;
	logic               we;
	logic               in_range;

	assign we      = wr.en && (32'(wr.slot) < BRANCH_ENTRIES);
	assign wr_addr = IDX_W'(wr.slot);
	assign wdata   = '{offset: wr.offset, dest: wr.dest};

	// first restarts the walk at the head of the table
	assign p_eff    = lk.first ? '0 : ptr_q;
	assign cur      = lk.first ? ent0_q : pre_q;
	assign in_range = (p_eff < branch_count) && (32'(p_eff) < BRANCH_ENTRIES);

	assign match.hit  = lk.en && in_range && (cur.offset == lk.address);
	assign match.dest = cur.dest;

	always_comb begin
		if (match.hit) begin
			ptr_next = p_eff + COUNT_W'(1);
		end else if (lk.en) begin
			ptr_next = p_eff;
		end else begin
			ptr_next = ptr_q;
		end
	end

	assign rd_addr = IDX_W'(ptr_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else begin
			ptr_q <= ptr_next;
		end
	end

	// prefetch the entry at the next pointer, bypassing a same-cycle write
	always_ff @(posedge clk) begin
		if (we) begin
			br_mem[wr_addr] <= wdata;
		end
		if (we && (wr_addr == rd_addr)) begin
			pre_q <= wdata;
		end else begin
			pre_q <= br_mem[rd_addr];
		end
		if (we && (wr_addr == '0)) begin
			ent0_q <= wdata;
		end
	end

endmodule

`default_nettype wire

// ----- design/slr_addr_mod.sv -----
`default_nettype none

module slr_addr_mod
	import slr_pkg::*;
#(
	parameter int CODE_WORDS = 4096
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [MOD_W-1:0]  u,
	output logic      [ADDR_W-1:0] addr
);

	localparam int          CLOG   = $clog2(CODE_WORDS);
	localparam int          SHIFT  = MOD_W + CLOG;
	localparam int          R_W    = MOD_W + 2;
	localparam int          PROD_W = MOD_W + R_W;
	localparam logic [63:0] RECIP  = ((64'd1 << SHIFT) + 64'(CODE_WORDS) - 64'd1)
		/ 64'(CODE_WORDS);

	logic [PROD_W-1:0] prod;
	logic [MOD_W-1:0]  quot;
	logic [MOD_W-1:0]  u_s2;
	logic [MOD_W-1:0]  quot_s2;
	logic [MOD_W-1:0]  rem;

	// reciprocal multiply gives the exact quotient for any u below 2^MOD_W
	assign prod = PROD_W'(u) * PROD_W'(R_W'(RECIP));
	assign quot = MOD_W'(prod >> SHIFT);

	always_ff @(posedge clk) begin
		if (en) begin
			u_s2    <= u;
			quot_s2 <= quot;
		end
	end

	assign rem  = u_s2 - quot_s2 * MOD_W'(CODE_WORDS);
	assign addr = rem[ADDR_W-1:0];

endmodule

`default_nettype wire

// ----- design/segment_relocating_loader.sv -----
// Segment relocating loader.
// Requests arrive on the s_axis channel: tuser carries the command and the
// first flag, tdata the segment, address, length, branch slot, destination
// segment and code word. Segment, order and branch requests load the tables
// and produce nothing; each code-word request produces one result on the
// m_axis channel with the execution address, the (possibly patched) word in
// tdata and the patched flag in tuser.
// The user writes branch_count through cfg_wr_en / cfg_wr_data, only while no
// request is in flight; the block has no check that enforces this.
// One request is accepted every cycle while s_axis_tready is high. A code-word
// result passes through stage 1, which registers the segment table reads,
// stage 2, which registers the quotient of the modulo reduction of the
// execution address, and the result register that drives m_axis_tvalid.
// Reset clears the running offset, the branch pointer, branch_count and all
// valid flags; the tables hold nothing defined until loaded.
// When the receiver stalls, the three stages fill and s_axis_tready drops
// only once the result register and both stages hold code words.
`default_nettype none

module segment_relocating_loader
	import slr_pkg::*;
#(
	parameter int SEGMENTS       = 16,
	parameter int CODE_WORDS     = 4096,
	parameter int BRANCH_ENTRIES = 256
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [COUNT_W-1:0]    cfg_wr_data,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// seg_id, address, seg_length, branch_index, dest_seg, code_word, zero pad
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// cmd, first
	input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// exec_address, exec_word, zero pad
	output logic      [OUT_DATA_W-1:0] m_axis_tdata,
	// patched
	output logic                       m_axis_tuser
);

	localparam int SW  = $clog2(SEGMENTS);
	localparam int OFS = CODE_WORDS * ((4095 + CODE_WORDS - 1) / CODE_WORDS);

	function automatic logic [SW-1:0] seg_reduce(input logic [SEGID_W-1:0] v);
		logic [SEGID_W-1:0] t;
		t = v;
		for (int i = 0; i < 8; i++) begin
			if (32'(t) >= SEGMENTS) begin
				t = t - SEGID_W'(SEGMENTS);
			end
		end
		return SW'(t);
	endfunction

	cmd_t               cmd_in;
	logic               first_in;
	logic [SEGID_W-1:0] seg_id_in;
	logic [ADDR_W-1:0]  address_in;
	logic [LEN_W-1:0]   seg_length_in;
	logic [SLOT_W-1:0]  branch_index_in;
	logic [SEGID_W-1:0] dest_seg_in;
	logic [WORD_W-1:0]  code_word_in;

	assign cmd_in          = s_axis_tuser[1:0];
	assign first_in        = s_axis_tuser[2];
	assign seg_id_in       = s_axis_tdata[3:0];
	assign address_in      = s_axis_tdata[15:4];
	assign seg_length_in   = s_axis_tdata[28:16];
	assign branch_index_in = s_axis_tdata[36:29];
	assign dest_seg_in     = s_axis_tdata[40:37];
	assign code_word_in    = s_axis_tdata[72:41];

	logic [COUNT_W-1:0] branch_count_q;
	logic               accept;
	br_write_t          br_wr;
	br_lookup_t         br_lk;
	br_match_t          br_hit;
	logic [SW-1:0]      seg_a;
	logic [SW-1:0]      seg_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			branch_count_q <= '0;
		end else if (cfg_wr_en) begin
			branch_count_q <= cfg_wr_data;
		end
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	assign br_wr = '{en: accept && (cmd_in == CMD_BRANCH), slot: branch_index_in,
		offset: address_in, dest: dest_seg_in};
	assign br_lk = '{en: accept && (cmd_in == CMD_CODE), first: first_in,
		address: address_in};

	slr_branch_match #(
		.BRANCH_ENTRIES(BRANCH_ENTRIES)
	) u_branch (
		.clk         (clk),
		.arst_n      (arst_n),
		.branch_count(branch_count_q),
		.wr          (br_wr),
		.lk          (br_lk),
		.match       (br_hit)
	);

	assign seg_a = seg_reduce(seg_id_in);
	assign seg_b = seg_reduce(br_hit.dest);

	// stage 1
	logic               s1_v;
	cmd_t               cmd_s1;
	logic               first_s1;
	logic [SW-1:0]      seg_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [LEN_W-1:0]   len_s1;
	logic [WORD_W-1:0]  word_s1;
	logic               hit_s1;
	logic [ADDR_W-1:0]  load_a_s1;
	logic [ADDR_W-1:0]  load_b_s1;
	logic [EXEC_W-1:0]  exec_a_s1;
	logic [EXEC_W-1:0]  exec_b_s1;
	logic [LEN_W-1:0]   size_a_s1;

	logic [ADDR_W-1:0]  load_mem [SEGMENTS];
	logic [LEN_W-1:0]   size_mem [SEGMENTS];
	logic [EXEC_W-1:0]  exec_mem [SEGMENTS];
	logic [EXEC_W-1:0]  run_q;
	logic [EXEC_W-1:0]  run_cur;

	// stage 2 and result register
	logic               s2_v;
	logic [WORD_W-1:0]  word_s2;
	logic               hit_s2;
	logic               out_v_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [WORD_W-1:0]  out_word_q;
	logic               out_hit_q;
	logic [ADDR_W-1:0]  exec_addr;

	logic               ready_out;
	logic               ready_s2;
	logic               s1_leave;
	logic               s2_load;
	logic               s2_move;
	logic               ld_we;
	logic               ex_we;
	logic [MOD_W-1:0]   u_s1;
	logic [JUMP_W-1:0]  jump;
	logic [JUMP_W-1:0]  low_s1;
	logic [WORD_W-1:0]  res_word_s1;

	assign ready_out     = !out_v_q || m_axis_tready;
	assign ready_s2      = !s2_v || ready_out;
	assign s1_leave      = s1_v && ((cmd_s1 != CMD_CODE) || ready_s2);
	assign s_axis_tready = !s1_v || s1_leave;
	assign s2_load       = s1_v && (cmd_s1 == CMD_CODE) && ready_s2;
	assign s2_move       = s2_v && ready_out;

	assign ld_we   = s1_leave && (cmd_s1 == CMD_SEG);
	assign ex_we   = s1_leave && (cmd_s1 == CMD_ORDER);
	assign run_cur = first_s1 ? '0 : run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v    <= 1'b0;
			s2_v    <= 1'b0;
			out_v_q <= 1'b0;
			run_q   <= '0;
		end else begin
			if (accept) begin
				s1_v <= 1'b1;
			end else if (s1_leave) begin
				s1_v <= 1'b0;
			end
			if (s2_load) begin
				s2_v <= 1'b1;
			end else if (s2_move) begin
				s2_v <= 1'b0;
			end
			if (s2_move) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			if (ex_we) begin
				run_q <= run_cur + size_a_s1;
			end
		end
	end

	// table writes leave from stage 1; reads at acceptance bypass them
	always_ff @(posedge clk) begin
		if (ld_we) begin
			load_mem[seg_s1] <= addr_s1;
			size_mem[seg_s1] <= len_s1;
		end
		if (ex_we) begin
			exec_mem[seg_s1] <= run_cur;
		end
		if (accept) begin
			cmd_s1   <= cmd_in;
			first_s1 <= first_in;
			seg_s1   <= seg_a;
			addr_s1  <= address_in;
			len_s1   <= seg_length_in;
			word_s1  <= code_word_in;
			hit_s1   <= br_hit.hit;
			load_a_s1 <= (ld_we && (seg_s1 == seg_a)) ? addr_s1 : load_mem[seg_a];
			load_b_s1 <= (ld_we && (seg_s1 == seg_b)) ? addr_s1 : load_mem[seg_b];
			size_a_s1 <= (ld_we && (seg_s1 == seg_a)) ? len_s1 : size_mem[seg_a];
			exec_a_s1 <= (ex_we && (seg_s1 == seg_a)) ? run_cur : exec_mem[seg_a];
			exec_b_s1 <= (ex_we && (seg_s1 == seg_b)) ? run_cur : exec_mem[seg_b];
		end
	end

	assign u_s1 = MOD_W'(addr_s1) + MOD_W'(exec_a_s1) + MOD_W'(OFS) - MOD_W'(load_a_s1);
	assign jump = JUMP_W'(exec_b_s1) - JUMP_W'(load_b_s1)
		- JUMP_W'(exec_a_s1) + JUMP_W'(load_a_s1);
	assign low_s1      = word_s1[JUMP_W-1:0] + jump;
	assign res_word_s1 = hit_s1 ? {word_s1[WORD_W-1:JUMP_W], low_s1} : word_s1;

	slr_addr_mod #(
		.CODE_WORDS(CODE_WORDS)
	) u_mod (
		.clk (clk),
		.en  (s2_load),
		.u   (u_s1),
		.addr(exec_addr)
	);

	always_ff @(posedge clk) begin
		if (s2_load) begin
			word_s2 <= res_word_s1;
			hit_s2  <= hit_s1;
		end
		if (s2_move) begin
			out_addr_q <= exec_addr;
			out_word_q <= word_s2;
			out_hit_q  <= hit_s2;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {4'b0, out_word_q, out_addr_q};
	assign m_axis_tuser  = out_hit_q;

endmodule

`default_nettype wire

// ----- design/slr_checker.sv -----
`default_nettype none

module slr_checker
	import slr_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic [IN_USER_W-1:0]  s_axis_tuser,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic                  m_axis_tuser
);

	logic code_req;

	assign code_req = s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == CMD_CODE);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("request refused with empty result register");

	a_code_latency: assert property (@(posedge clk) disable iff (!arst_n)
		code_req ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("code word result missing");

endmodule

bind segment_relocating_loader slr_checker u_slr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

`default_nettype wire
